// ===== hdl/skf_pkg.sv =====
// Package for the scalar Kalman filter core: widths, reset values,
// register index codes and the sequencer state type. No dependencies.
package skf_pkg;

	localparam int SampleWidthDef = 16;
	localparam int DataWidth      = 32;
	localparam int VarWidth       = 34;
	localparam int DenWidth       = VarWidth + 1;
	localparam int GainWidth      = 17;
	localparam int FracBits       = 16;
	localparam int CfgIndexWidth  = 8;

	localparam logic [GainWidth-1:0] FracOne = 17'h1_0000;
	localparam logic [VarWidth-1:0]  PInit   = 34'd196608;
	localparam logic [DataWidth-1:0] QReset  = 32'd655;
	localparam logic [DataWidth-1:0] RReset  = 32'd65536;

	localparam logic [CfgIndexWidth-1:0] RegProcessNoise     = 8'd0;
	localparam logic [CfgIndexWidth-1:0] RegMeasurementNoise = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_Q,
		ST_ADD_R,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} skf_state_t;

endpackage

// ===== hdl/skf_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
// Expects num <= den; standalone, no package needed.
module skf_serial_div #(
	parameter int DEN_WIDTH = 35,
	parameter int QUO_WIDTH = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DEN_WIDTH-1:0] num,
	input  logic [DEN_WIDTH-1:0] den,
	output logic                 busy,
	output logic [QUO_WIDTH-1:0] quotient
);
	localparam int CNT_WIDTH = $clog2(QUO_WIDTH + 1);

	logic [DEN_WIDTH:0]   rem_q;
	logic [DEN_WIDTH-1:0] den_q;
	logic [QUO_WIDTH-1:0] quo_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [DEN_WIDTH+1:0] diff;
	logic                 ge;
	logic [DEN_WIDTH:0]   keep;

	assign diff = {1'b0, rem_q} - {2'b0, den_q};
	assign ge   = ~diff[DEN_WIDTH+1];
	assign keep = ge ? diff[DEN_WIDTH:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
			cnt_q <= CNT_WIDTH'(QUO_WIDTH);
		end else if (cnt_q != '0) begin
			rem_q <= {keep[DEN_WIDTH-1:0], 1'b0};
			quo_q <= {quo_q[QUO_WIDTH-2:0], ge};
			cnt_q <= cnt_q - CNT_WIDTH'(1);
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

// ===== hdl/skf_serial_mul.sv =====
// Shift-add multiplier: signed multiplicand, unsigned multiplier taken
// one bit per cycle, LSB first. Standalone, no package needed.
module skf_serial_mul #(
	parameter int A_WIDTH = 41,
	parameter int B_WIDTH = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [A_WIDTH-1:0]         a,
	input  logic        [B_WIDTH-1:0]         b,
	output logic                              busy,
	output logic signed [A_WIDTH+B_WIDTH-1:0] product
);
	localparam int P_WIDTH   = A_WIDTH + B_WIDTH;
	localparam int CNT_WIDTH = $clog2(B_WIDTH + 1);

	logic signed [P_WIDTH-1:0] a_q;
	logic        [B_WIDTH-1:0] b_q;
	logic signed [P_WIDTH-1:0] acc_q;
	logic [CNT_WIDTH-1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			a_q   <= {{B_WIDTH{a[A_WIDTH-1]}}, a};
			b_q   <= b;
			acc_q <= '0;
			cnt_q <= CNT_WIDTH'(B_WIDTH);
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q   <= a_q <<< 1;
			b_q   <= b_q >> 1;
			cnt_q <= cnt_q - CNT_WIDTH'(1);
		end
	end

	assign busy    = (cnt_q != '0);
	assign product = acc_q;

endmodule

// ===== hdl/scalar_kalman_filter_core.sv =====
// Scalar Kalman filter core (A = H = 1): sequencer, state and config registers.
// Depends on skf_pkg, skf_serial_div and skf_serial_mul.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+-----------------
//   in      | in_valid, in_stall, measurement          | sample in
//   out     | out_valid, out_stall, filtered_value,gain | estimate out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// An item passes two add states (ADD_Q, ADD_R), the serial divider (17 gain bits),
// the two serial multipliers side by side and the update state (FIN); in_stall stays
// high until the sequencer is back in IDLE, so a new item waits until the last is done.
// Reset loads Q = 655, R = 1.0, estimate 0 and variance 3.0.
// A result waits in the output register while out_stall is high; the next item is
// accepted meanwhile and holds in its update cycle until the slot frees.
module scalar_kalman_filter_core #(
	parameter int SAMPLE_WIDTH = skf_pkg::SampleWidthDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      measurement,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [skf_pkg::DataWidth-1:0] filtered_value,
	output logic [skf_pkg::GainWidth-1:0]       gain,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [skf_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [skf_pkg::DataWidth-1:0]       cfg_data
);
	import skf_pkg::*;

	localparam int MEAS_WIDTH = SAMPLE_WIDTH + FracBits;
	localparam int RES_WIDTH  = ((MEAS_WIDTH > DataWidth) ? MEAS_WIDTH : DataWidth) + 1;
	localparam int PRD_WIDTH  = RES_WIDTH + GainWidth;
	localparam int SUM_WIDTH  = RES_WIDTH + 2;
	localparam int VPA_WIDTH  = VarWidth + 1;
	localparam int VPR_WIDTH  = VPA_WIDTH + GainWidth;

	skf_state_t state_q, state_d;

	logic                         div_start, mul_start, fin_load;
	logic                         div_busy, res_busy, var_busy;
	logic [GainWidth-1:0]         quotient;

	logic [DataWidth-1:0]         q_q, r_q;
	logic signed [DataWidth-1:0]  est_q;
	logic [VarWidth-1:0]          pvar_q;
	logic signed [SAMPLE_WIDTH-1:0] meas_q;
	logic [VarWidth-1:0]          p_q;
	logic signed [RES_WIDTH-1:0]  residual_q;
	logic                         den_zero_q;
	logic [GainWidth-1:0]         gain_q;
	logic                         out_valid_q;
	logic signed [DataWidth-1:0]  out_value_q;
	logic [GainWidth-1:0]         out_gain_q;

	logic [VarWidth:0]            p_sum;
	logic [VarWidth-1:0]          p_sat;
	logic [DenWidth-1:0]          den;
	logic signed [RES_WIDTH-1:0]  meas_ext, est_ext;
	logic [GainWidth-1:0]         gain_new;
	logic [GainWidth-1:0]         one_minus;
	logic signed [PRD_WIDTH-1:0]  res_prod;
	logic signed [VPR_WIDTH-1:0]  var_prod;
	logic signed [SUM_WIDTH-1:0]  est_sum;
	logic signed [DataWidth-1:0]  est_next;
	logic                         cfg_wr;
	logic                         cfg_restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_ADD_Q;
				end
			end
			ST_ADD_Q: begin
				state_d = ST_ADD_R;
			end
			ST_ADD_R: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!res_busy && !var_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign p_sum    = {1'b0, pvar_q} + {{(VarWidth + 1 - DataWidth){1'b0}}, q_q};
	assign p_sat    = p_sum[VarWidth] ? '1 : p_sum[VarWidth-1:0];
	assign den      = {1'b0, p_q} + {{(DenWidth - DataWidth){1'b0}}, r_q};
	assign meas_ext = {{(RES_WIDTH - MEAS_WIDTH){meas_q[SAMPLE_WIDTH-1]}}, meas_q,
		{FracBits{1'b0}}};
	assign est_ext  = {{(RES_WIDTH - DataWidth){est_q[DataWidth-1]}}, est_q};
	assign gain_new = den_zero_q ? FracOne : quotient;
	assign one_minus = FracOne - gain_new;

	assign est_sum = {{(SUM_WIDTH - DataWidth){est_q[DataWidth-1]}}, est_q}
		+ {res_prod[PRD_WIDTH-1], res_prod[PRD_WIDTH-1:FracBits]};

	always_comb begin
		if (est_sum[SUM_WIDTH-1:DataWidth-1] == '0
				|| est_sum[SUM_WIDTH-1:DataWidth-1] == '1) begin
			est_next = est_sum[DataWidth-1:0];
		end else if (est_sum[SUM_WIDTH-1]) begin
			est_next = {1'b1, {(DataWidth - 1){1'b0}}};
		end else begin
			est_next = {1'b0, {(DataWidth - 1){1'b1}}};
		end
	end

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_wr && (cfg_index inside {RegProcessNoise, RegMeasurementNoise});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q         <= QReset;
			r_q         <= RReset;
			est_q       <= '0;
			pvar_q      <= PInit;
			meas_q      <= '0;
			p_q         <= '0;
			residual_q  <= '0;
			den_zero_q  <= 1'b0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_gain_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				meas_q <= measurement;
			end
			if (state_q == ST_ADD_Q) begin
				p_q        <= p_sat;
				residual_q <= meas_ext - est_ext;
			end
			if (div_start) begin
				den_zero_q <= (den == '0);
			end
			if (mul_start) begin
				gain_q <= gain_new;
			end
			if (cfg_restart) begin
				est_q  <= '0;
				pvar_q <= PInit;
			end else if (fin_load) begin
				est_q  <= est_next;
				pvar_q <= var_prod[VarWidth+FracBits-1:FracBits];
			end
			if (fin_load) begin
				out_value_q <= est_next;
				out_gain_q  <= gain_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (cfg_index)
					RegProcessNoise: begin
						q_q <= cfg_data;
					end
					RegMeasurementNoise: begin
						r_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	skf_serial_div #(
		.DEN_WIDTH (DenWidth),
		.QUO_WIDTH (GainWidth)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      ({1'b0, p_q}),
		.den      (den),
		.busy     (div_busy),
		.quotient (quotient)
	);

	skf_serial_mul #(
		.A_WIDTH (RES_WIDTH),
		.B_WIDTH (GainWidth)
	) u_res_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (residual_q),
		.b       (gain_new),
		.busy    (res_busy),
		.product (res_prod)
	);

	skf_serial_mul #(
		.A_WIDTH (VPA_WIDTH),
		.B_WIDTH (GainWidth)
	) u_var_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ({1'b0, p_q}),
		.b       (one_minus),
		.busy    (var_busy),
		.product (var_prod)
	);

	assign out_valid      = out_valid_q;
	assign filtered_value = out_value_q;
	assign gain           = out_gain_q;

endmodule
